/* sv/anc_pkg.sv */
// Types, codes and helpers for the ARP neighbor cache.
// Used by anc_ram-free logic in arp_neighbor_cache_top; no dependencies.
`default_nettype none

package anc_pkg;

   // command codes
   typedef enum logic [2:0] {
      CMD_LOOKUP  = 3'd0,
      CMD_RESOLVE = 3'd1,
      CMD_LEARN   = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_FLUSH   = 3'd4,
      CMD_TICK    = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [3:0] {
      ST_HIT        = 4'd0,
      ST_MISS       = 4'd1,
      ST_QUEUED     = 4'd2,
      ST_SEND_NOW   = 4'd3,
      ST_CREATED    = 4'd4,
      ST_UPDATED    = 4'd5,
      ST_REMOVED    = 4'd6,
      ST_NOT_FOUND  = 4'd7,
      ST_TABLE_FULL = 4'd8,
      ST_RETRY      = 4'd9,
      ST_RES_FAILED = 4'd10,
      ST_TICK_DONE  = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      PH_INCOMPLETE = 2'd0,
      PH_REACHABLE  = 2'd1,
      PH_STALE      = 2'd2
   } phase_type;

   // configuration register indexes
   localparam logic [1:0] REG_REACH_TMO  = 2'd0;
   localparam logic [1:0] REG_INCOMP_TMO = 2'd1;
   localparam logic [1:0] REG_RETRY_INT  = 2'd2;
   localparam logic [1:0] REG_MAX_RETRY  = 2'd3;

   localparam logic [31:0] LOOPBACK_MASK = 32'hFF00_0000;
   localparam logic [31:0] LOOPBACK_NET  = 32'h7F00_0000;
   localparam logic [47:0] LOOPBACK_MAC  = 48'h01;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_SCAN_RD,
      SQ_SCAN_EV,
      SQ_ACT_RD,
      SQ_ACT_EV,
      SQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] ip_addr;
      logic [47:0] hw_addr;
      logic [3:0]  dev_id;
      logic        flush_all;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [47:0] hw_addr_out;
      logic        send_request;
      logic [31:0] request_ip;
      logic        released_pending;
      logic        dropped_pending;
      logic        last;
   } rsp_type;

   // one table entry as stored in RAM
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      phase_type   phase;
      logic [3:0]  retries;
      logic [16:0] timer;
      logic [31:0] last_use;
      logic [3:0]  iface;
      logic        pending;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // a timeout of zero behaves as one
   function automatic logic [16:0] tmo(input logic [15:0] v);
      logic [16:0] r;
      r = (v == 16'd0) ? 17'd1 : {1'b0, v};
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/arp_neighbor_cache_top.sv */
// ARP neighbor cache: IPv4-to-MAC table with LRU eviction and timers.
// Depends on anc_pkg and anc_ram.
//
// Use: commands arrive on req_* (valid/ready), results leave on rsp_*
// (valid/ready). One command gives one or more results; the final one has
// last set. Commands 6 and 7 are taken and give no result.
// Configuration: csr_we with csr_index/csr_wdata writes a register; write
// only while the block is idle.
// Flow: a loopback lookup goes straight to the final result. Every other
// defined command walks all TABLE_ENTRIES slots through the entry RAM, each
// slot as an address step, then registered read data and write-back.
// Lookup, resolve, learn and delete then do one more read-modify-write of
// the chosen slot. One command is in work at a time; req_ready is high
// only between commands.
// Results pass through a one-entry hold register and the rsp register, so
// a command can be accepted while its predecessor's last result still
// waits. If the receiver stalls, flush and tick walks pause on the slot
// that produced a result until the rsp register frees up.
// Reset: all slots invalid, tick clock zero, registers at defaults; no
// clearing pass is needed, slot valid bits live in flip-flops.
`default_nettype none

module arp_neighbor_cache_top #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire anc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output anc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   // configuration
   logic [15:0] reach_tmo_ff, incomp_tmo_ff, retry_int_ff;
   logic [3:0]  max_retry_ff;

   // sequencer state
   anc_pkg::seq_state_type state_ff, state_in;
   logic [IW-1:0]          idx_ff, idx_in;
   anc_pkg::req_type       req_ff, req_in;
   logic                   m_found_ff, m_found_in;
   logic [IW-1:0]          m_idx_ff, m_idx_in;
   logic                   f_found_ff, f_found_in;
   logic [IW-1:0]          f_idx_ff, f_idx_in;
   logic                   v_found_ff, v_found_in;
   logic [IW-1:0]          v_idx_ff, v_idx_in;
   logic [31:0]            v_best_ff, v_best_in;
   logic [IW-1:0]          target_ff, target_in;
   logic                   hold_valid_ff, hold_valid_in;
   anc_pkg::rsp_type       hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   anc_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]            tick_clock_ff, tick_clock_in;

   // entry RAM
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   anc_pkg::entry_type   ram_wdata, ram_rdata;

   anc_ram #(
      .WIDTH (anc_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready = (state_ff == anc_pkg::SQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign ram_raddr = (state_ff == anc_pkg::SQ_ACT_RD) ? target_ff : idx_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_tmo_ff  <= 16'd60;
         incomp_tmo_ff <= 16'd3;
         retry_int_ff  <= 16'd1;
         max_retry_ff  <= 4'd3;
      end else if (csr_we) begin
         case (csr_index)
            anc_pkg::REG_REACH_TMO:  reach_tmo_ff  <= csr_wdata;
            anc_pkg::REG_INCOMP_TMO: incomp_tmo_ff <= csr_wdata;
            anc_pkg::REG_RETRY_INT:  retry_int_ff  <= csr_wdata;
            anc_pkg::REG_MAX_RETRY:  max_retry_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= anc_pkg::SQ_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         tick_clock_ff <= '0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         tick_clock_ff <= tick_clock_in;
      end
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      m_found_ff  <= m_found_in;
      m_idx_ff    <= m_idx_in;
      f_found_ff  <= f_found_in;
      f_idx_ff    <= f_idx_in;
      v_found_ff  <= v_found_in;
      v_idx_ff    <= v_idx_in;
      v_best_ff   <= v_best_in;
      target_ff   <= target_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: next state, table updates and results
   always_comb begin
      logic               out_free;
      logic               res_fire;
      anc_pkg::rsp_type   res;
      anc_pkg::entry_type w;
      logic               cur_valid;
      logic [16:0]        tdec;
      logic               new_reach;

      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      m_found_in    = m_found_ff;
      m_idx_in      = m_idx_ff;
      f_found_in    = f_found_ff;
      f_idx_in      = f_idx_ff;
      v_found_in    = v_found_ff;
      v_idx_in      = v_idx_ff;
      v_best_in     = v_best_ff;
      target_in     = target_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      valid_in      = valid_ff;
      tick_clock_in = tick_clock_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      w             = ram_rdata;
      ram_wdata     = w;
      res_fire      = 1'b0;
      res           = '0;
      cur_valid     = valid_ff[idx_ff];
      tdec          = ram_rdata.timer - 17'd1;
      new_reach     = (req_ff.hw_addr != 48'd0);

      out_free = !rsp_valid_ff || rsp_ready;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         anc_pkg::SQ_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               idx_in     = '0;
               m_found_in = 1'b0;
               f_found_in = 1'b0;
               v_found_in = 1'b0;
               case (req_data.command)
                  anc_pkg::CMD_LOOKUP: begin
                     if ((req_data.ip_addr & anc_pkg::LOOPBACK_MASK) ==
                         anc_pkg::LOOPBACK_NET) begin
                        res_fire         = 1'b1;
                        res.status       = anc_pkg::ST_HIT;
                        res.hw_addr_out  = anc_pkg::LOOPBACK_MAC;
                        res.request_ip   = req_data.ip_addr;
                        state_in         = anc_pkg::SQ_FINISH;
                     end else begin
                        state_in = anc_pkg::SQ_SCAN_RD;
                     end
                  end
                  anc_pkg::CMD_RESOLVE, anc_pkg::CMD_LEARN, anc_pkg::CMD_DELETE,
                  anc_pkg::CMD_FLUSH: begin
                     state_in = anc_pkg::SQ_SCAN_RD;
                  end
                  anc_pkg::CMD_TICK: begin
                     tick_clock_in = tick_clock_ff + 32'd1;
                     state_in      = anc_pkg::SQ_SCAN_RD;
                  end
                  default: state_in = anc_pkg::SQ_IDLE;
               endcase
            end
         end

         // address of slot idx is presented; data arrives next cycle
         anc_pkg::SQ_SCAN_RD: begin
            state_in = anc_pkg::SQ_SCAN_EV;
         end

         anc_pkg::SQ_SCAN_EV: begin
            if (req_ff.command == anc_pkg::CMD_FLUSH) begin
               if (cur_valid && (req_ff.flush_all || ram_rdata.iface == req_ff.dev_id)) begin
                  res_fire            = 1'b1;
                  res.status          = anc_pkg::ST_REMOVED;
                  res.request_ip      = ram_rdata.ip;
                  res.dropped_pending = ram_rdata.pending;
               end
            end else if (req_ff.command == anc_pkg::CMD_TICK) begin
               if (cur_valid && ram_rdata.timer != 17'd0) begin
                  ram_we  = 1'b1;
                  w.timer = tdec;
                  if (tdec == 17'd0) begin
                     if (ram_rdata.phase == anc_pkg::PH_INCOMPLETE) begin
                        res_fire = 1'b1;
                        res.request_ip = ram_rdata.ip;
                        if (ram_rdata.retries < max_retry_ff) begin
                           w.retries        = ram_rdata.retries + 4'd1;
                           w.timer          = anc_pkg::tmo(retry_int_ff);
                           res.status       = anc_pkg::ST_RETRY;
                           res.send_request = 1'b1;
                        end else begin
                           res.status          = anc_pkg::ST_RES_FAILED;
                           res.dropped_pending = ram_rdata.pending;
                        end
                     end else if (ram_rdata.phase == anc_pkg::PH_REACHABLE) begin
                        w.phase = anc_pkg::PH_STALE;
                     end
                  end
               end
            end else begin
               // match, first free slot and LRU victim
               if (cur_valid && ram_rdata.ip == req_ff.ip_addr && !m_found_ff) begin
                  m_found_in = 1'b1;
                  m_idx_in   = idx_ff;
               end
               if (!cur_valid && !f_found_ff) begin
                  f_found_in = 1'b1;
                  f_idx_in   = idx_ff;
               end
               if (cur_valid && ram_rdata.phase != anc_pkg::PH_INCOMPLETE &&
                   (!v_found_ff || ram_rdata.last_use < v_best_ff)) begin
                  v_found_in = 1'b1;
                  v_idx_in   = idx_ff;
                  v_best_in  = ram_rdata.last_use;
               end
            end

            if (res_fire && hold_valid_ff && !out_free) begin
               // receiver stalled: retry this slot next cycle
               res_fire = 1'b0;
               ram_we   = 1'b0;
            end else begin
               if (res_fire && (req_ff.command == anc_pkg::CMD_FLUSH ||
                                res.status == anc_pkg::ST_RES_FAILED)) begin
                  valid_in[idx_ff] = 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  if (req_ff.command == anc_pkg::CMD_FLUSH ||
                      req_ff.command == anc_pkg::CMD_TICK) begin
                     state_in = anc_pkg::SQ_FINISH;
                  end else begin
                     state_in = anc_pkg::SQ_ACT_RD;
                     if (m_found_in)      target_in = m_idx_in;
                     else if (f_found_in) target_in = f_idx_in;
                     else                 target_in = v_idx_in;
                  end
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = anc_pkg::SQ_SCAN_RD;
               end
            end
            ram_wdata = w;
         end

         anc_pkg::SQ_ACT_RD: begin
            state_in = anc_pkg::SQ_ACT_EV;
         end

         // read-modify-write of the chosen slot
         anc_pkg::SQ_ACT_EV: begin
            ram_waddr      = target_ff;
            res_fire       = 1'b1;
            res.request_ip = req_ff.ip_addr;
            state_in       = anc_pkg::SQ_FINISH;
            if (m_found_ff) begin
               // touch
               w.last_use = tick_clock_ff;
               if (ram_rdata.phase == anc_pkg::PH_REACHABLE) begin
                  w.timer = anc_pkg::tmo(reach_tmo_ff);
               end
               ram_we = 1'b1;
               case (req_ff.command)
                  anc_pkg::CMD_LOOKUP: begin
                     if (ram_rdata.phase == anc_pkg::PH_REACHABLE) begin
                        res.status      = anc_pkg::ST_HIT;
                        res.hw_addr_out = ram_rdata.mac;
                     end else begin
                        res.status = anc_pkg::ST_MISS;
                     end
                  end
                  anc_pkg::CMD_RESOLVE: begin
                     if (ram_rdata.phase == anc_pkg::PH_REACHABLE) begin
                        res.status      = anc_pkg::ST_SEND_NOW;
                        res.hw_addr_out = ram_rdata.mac;
                     end else if (ram_rdata.phase == anc_pkg::PH_INCOMPLETE) begin
                        w.pending  = 1'b1;
                        res.status = anc_pkg::ST_QUEUED;
                     end else begin
                        w.phase          = anc_pkg::PH_INCOMPLETE;
                        w.retries        = 4'd0;
                        w.timer          = anc_pkg::tmo(incomp_tmo_ff);
                        w.pending        = 1'b1;
                        res.status       = anc_pkg::ST_QUEUED;
                        res.send_request = 1'b1;
                     end
                  end
                  anc_pkg::CMD_LEARN: begin
                     res.status = anc_pkg::ST_UPDATED;
                     if (new_reach) begin
                        w.mac                = req_ff.hw_addr;
                        w.phase              = anc_pkg::PH_REACHABLE;
                        w.retries            = 4'd0;
                        w.timer              = anc_pkg::tmo(reach_tmo_ff);
                        w.pending            = 1'b0;
                        res.released_pending = ram_rdata.pending;
                     end
                  end
                  default: begin
                     // delete
                     ram_we              = 1'b0;
                     valid_in[target_ff] = 1'b0;
                     res.status          = anc_pkg::ST_REMOVED;
                     res.dropped_pending = ram_rdata.pending;
                  end
               endcase
            end else if (req_ff.command == anc_pkg::CMD_LOOKUP) begin
               res.status = anc_pkg::ST_MISS;
            end else if (req_ff.command == anc_pkg::CMD_DELETE) begin
               res.status = anc_pkg::ST_NOT_FOUND;
            end else if (!f_found_ff && !v_found_ff) begin
               res.status = anc_pkg::ST_TABLE_FULL;
            end else begin
               // new entry in a free or evicted slot
               ram_we              = 1'b1;
               valid_in[target_ff] = 1'b1;
               w.ip       = req_ff.ip_addr;
               w.retries  = 4'd0;
               w.last_use = tick_clock_ff;
               w.iface    = req_ff.dev_id;
               if (req_ff.command == anc_pkg::CMD_LEARN && new_reach) begin
                  w.mac   = req_ff.hw_addr;
                  w.phase = anc_pkg::PH_REACHABLE;
                  w.timer = anc_pkg::tmo(reach_tmo_ff);
               end else begin
                  w.mac   = 48'd0;
                  w.phase = anc_pkg::PH_INCOMPLETE;
                  w.timer = anc_pkg::tmo(incomp_tmo_ff);
               end
               if (req_ff.command == anc_pkg::CMD_RESOLVE) begin
                  w.pending        = 1'b1;
                  res.status       = anc_pkg::ST_QUEUED;
                  res.send_request = 1'b1;
               end else begin
                  w.pending  = 1'b0;
                  res.status = anc_pkg::ST_CREATED;
               end
            end
            ram_wdata = w;
         end

         // hand over the final result with last set
         anc_pkg::SQ_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_data_in      = hold_ff;
                  rsp_data_in.last = 1'b1;
                  hold_valid_in    = 1'b0;
               end else begin
                  rsp_data_in        = '0;
                  rsp_data_in.status = (req_ff.command == anc_pkg::CMD_FLUSH) ?
                                       anc_pkg::ST_NOT_FOUND : anc_pkg::ST_TICK_DONE;
                  rsp_data_in.last   = 1'b1;
               end
               state_in = anc_pkg::SQ_IDLE;
            end
         end

         default: state_in = anc_pkg::SQ_IDLE;
      endcase

      // a new result pushes the held one out, since it was not the last
      if (res_fire) begin
         if (hold_valid_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_data_in      = hold_ff;
            rsp_data_in.last = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = res;
      end
   end

   logic out_free_chk;
   assign out_free_chk = !rsp_valid_ff || rsp_ready;

   // hold register is always drained before the next command starts
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == anc_pkg::SQ_IDLE) |-> !hold_valid_ff)
      else $error("hold register occupied while idle");

   // the table is written only while a slot's read data is being evaluated
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == anc_pkg::SQ_SCAN_EV || state_ff == anc_pkg::SQ_ACT_EV))
      else $error("entry RAM written outside an evaluate step");

   // unknown commands give no result and leave the block idle
   a_unknown_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.command[2] && req_data.command[1])
      |=> (state_ff == anc_pkg::SQ_IDLE && !hold_valid_ff))
      else $error("unknown command started work");

   // a final result means the sequencer has returned to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == anc_pkg::SQ_FINISH && out_free_chk) |=> (state_ff == anc_pkg::SQ_IDLE))
      else $error("sequencer stuck after final result");

endmodule

`default_nettype wire

/* sv/anc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module anc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for arp_neighbor_cache_top: directed table, random traffic, then a table fill.
// Depends on anc_pkg and the RTL of the neighbor cache; reads no files.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 64;
   localparam int DRAIN_CYCLES = 400;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   anc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   anc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   arp_neighbor_cache_top #(.TABLE_ENTRIES(NSLOT)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // neighbor table shadow
   typedef struct {
      bit valid;
      bit [31:0] ip;
      bit [47:0] mac;
      anc_pkg::phase_type phase;
      bit [3:0] retries;
      bit [16:0] timer;
      bit [31:0] last_use;
      bit [3:0] iface;
      bit pending;
   } nbr_entry_type;

   nbr_entry_type nbr[NSLOT];
   bit [31:0] tick_count;
   bit [15:0] reach_tmo, incomp_tmo, retry_int;
   bit [3:0] retry_max;

   anc_pkg::rsp_type expected_rsp[$];
   int errors = 0;
   int rsp_seen = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycles = 0;
   bit [31:0] ip_pool[16];

   function automatic bit [16:0] eff_tmo(bit [15:0] v);
      return (v == 0) ? 17'd1 : {1'b0, v};
   endfunction

   function automatic void push_rsp(anc_pkg::status_type st, bit [47:0] mac, bit req,
                                    bit [31:0] ip, bit rel, bit drop);
      anc_pkg::rsp_type r;
      r.status = st;
      r.hw_addr_out = mac;
      r.send_request = req;
      r.request_ip = ip;
      r.released_pending = rel;
      r.dropped_pending = drop;
      r.last = 1'b0;
      expected_rsp.push_back(r);
   endfunction

   function automatic int find_ip(bit [31:0] ip);
      for (int i = 0; i < NSLOT; i++)
         if (nbr[i].valid && nbr[i].ip == ip) return i;
      return -1;
   endfunction

   function automatic void touch_entry(int i);
      nbr[i].last_use = tick_count;
      if (nbr[i].phase == anc_pkg::PH_REACHABLE) nbr[i].timer = eff_tmo(reach_tmo);
   endfunction

   // free slot first, else LRU among non-incomplete entries
   function automatic int pick_slot();
      int victim;
      bit [31:0] best;
      victim = -1;
      best = '0;
      for (int i = 0; i < NSLOT; i++)
         if (!nbr[i].valid) return i;
      for (int i = 0; i < NSLOT; i++) begin
         if (nbr[i].phase == anc_pkg::PH_INCOMPLETE) continue;
         if (victim < 0 || nbr[i].last_use < best) begin
            victim = i;
            best = nbr[i].last_use;
         end
      end
      if (victim >= 0) nbr[victim].valid = 0;
      return victim;
   endfunction

   function automatic void fill_entry(int i, bit [31:0] ip, bit [47:0] mac, bit [3:0] dev,
                                      bit reach, bit pend);
      nbr[i].valid = 1;
      nbr[i].ip = ip;
      nbr[i].mac = reach ? mac : '0;
      nbr[i].phase = reach ? anc_pkg::PH_REACHABLE : anc_pkg::PH_INCOMPLETE;
      nbr[i].retries = 0;
      nbr[i].timer = reach ? eff_tmo(reach_tmo) : eff_tmo(incomp_tmo);
      nbr[i].last_use = tick_count;
      nbr[i].iface = dev;
      nbr[i].pending = pend;
   endfunction

   // predicts the results of one command and appends them to expected_rsp
   function automatic void predict_cache(anc_pkg::req_type rq);
      int i, n0;
      bit rel;
      n0 = expected_rsp.size();
      case (rq.command)
         anc_pkg::CMD_LOOKUP: begin
            if ((rq.ip_addr & anc_pkg::LOOPBACK_MASK) == anc_pkg::LOOPBACK_NET)
               push_rsp(anc_pkg::ST_HIT, anc_pkg::LOOPBACK_MAC, 0, rq.ip_addr, 0, 0);
            else begin
               i = find_ip(rq.ip_addr);
               if (i >= 0) touch_entry(i);
               if (i >= 0 && nbr[i].phase == anc_pkg::PH_REACHABLE)
                  push_rsp(anc_pkg::ST_HIT, nbr[i].mac, 0, rq.ip_addr, 0, 0);
               else
                  push_rsp(anc_pkg::ST_MISS, 0, 0, rq.ip_addr, 0, 0);
            end
         end
         anc_pkg::CMD_RESOLVE: begin
            i = find_ip(rq.ip_addr);
            if (i < 0) begin
               i = pick_slot();
               if (i < 0) push_rsp(anc_pkg::ST_TABLE_FULL, 0, 0, rq.ip_addr, 0, 0);
               else begin
                  fill_entry(i, rq.ip_addr, 0, rq.dev_id, 0, 1);
                  push_rsp(anc_pkg::ST_QUEUED, 0, 1, rq.ip_addr, 0, 0);
               end
            end else begin
               touch_entry(i);
               if (nbr[i].phase == anc_pkg::PH_REACHABLE)
                  push_rsp(anc_pkg::ST_SEND_NOW, nbr[i].mac, 0, rq.ip_addr, 0, 0);
               else if (nbr[i].phase == anc_pkg::PH_INCOMPLETE) begin
                  nbr[i].pending = 1;
                  push_rsp(anc_pkg::ST_QUEUED, 0, 0, rq.ip_addr, 0, 0);
               end else begin
                  nbr[i].phase = anc_pkg::PH_INCOMPLETE;
                  nbr[i].retries = 0;
                  nbr[i].timer = eff_tmo(incomp_tmo);
                  nbr[i].pending = 1;
                  push_rsp(anc_pkg::ST_QUEUED, 0, 1, rq.ip_addr, 0, 0);
               end
            end
         end
         anc_pkg::CMD_LEARN: begin
            i = find_ip(rq.ip_addr);
            if (i >= 0) begin
               rel = 0;
               touch_entry(i);
               if (rq.hw_addr != 0) begin
                  nbr[i].mac = rq.hw_addr;
                  nbr[i].phase = anc_pkg::PH_REACHABLE;
                  nbr[i].retries = 0;
                  nbr[i].timer = eff_tmo(reach_tmo);
                  rel = nbr[i].pending;
                  nbr[i].pending = 0;
               end
               push_rsp(anc_pkg::ST_UPDATED, 0, 0, rq.ip_addr, rel, 0);
            end else begin
               i = pick_slot();
               if (i < 0) push_rsp(anc_pkg::ST_TABLE_FULL, 0, 0, rq.ip_addr, 0, 0);
               else begin
                  fill_entry(i, rq.ip_addr, rq.hw_addr, rq.dev_id, rq.hw_addr != 0, 0);
                  push_rsp(anc_pkg::ST_CREATED, 0, 0, rq.ip_addr, 0, 0);
               end
            end
         end
         anc_pkg::CMD_DELETE: begin
            i = find_ip(rq.ip_addr);
            if (i < 0) push_rsp(anc_pkg::ST_NOT_FOUND, 0, 0, rq.ip_addr, 0, 0);
            else begin
               nbr[i].valid = 0;
               push_rsp(anc_pkg::ST_REMOVED, 0, 0, rq.ip_addr, 0, nbr[i].pending);
            end
         end
         anc_pkg::CMD_FLUSH: begin
            for (i = 0; i < NSLOT; i++)
               if (nbr[i].valid && (rq.flush_all || nbr[i].iface == rq.dev_id)) begin
                  nbr[i].valid = 0;
                  push_rsp(anc_pkg::ST_REMOVED, 0, 0, nbr[i].ip, 0, nbr[i].pending);
               end
            if (expected_rsp.size() == n0) push_rsp(anc_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0);
         end
         anc_pkg::CMD_TICK: begin
            tick_count++;
            for (i = 0; i < NSLOT; i++) begin
               if (!nbr[i].valid || nbr[i].timer == 0) continue;
               nbr[i].timer--;
               if (nbr[i].timer != 0) continue;
               if (nbr[i].phase == anc_pkg::PH_INCOMPLETE) begin
                  if (nbr[i].retries < retry_max) begin
                     nbr[i].retries++;
                     nbr[i].timer = eff_tmo(retry_int);
                     push_rsp(anc_pkg::ST_RETRY, 0, 1, nbr[i].ip, 0, 0);
                  end else begin
                     nbr[i].valid = 0;
                     push_rsp(anc_pkg::ST_RES_FAILED, 0, 0, nbr[i].ip, 0, nbr[i].pending);
                  end
               end else if (nbr[i].phase == anc_pkg::PH_REACHABLE)
                  nbr[i].phase = anc_pkg::PH_STALE;
            end
            if (expected_rsp.size() == n0) push_rsp(anc_pkg::ST_TICK_DONE, 0, 0, 0, 0, 0);
         end
         default: ;
      endcase
      if (expected_rsp.size() > n0) expected_rsp[expected_rsp.size() - 1].last = 1'b1;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check each transfer against the oldest expectation
   always @(posedge clock) begin
      anc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status || rsp_data.hw_addr_out !== want.hw_addr_out
                || rsp_data.send_request !== want.send_request
                || rsp_data.request_ip !== want.request_ip
                || rsp_data.released_pending !== want.released_pending
                || rsp_data.dropped_pending !== want.dropped_pending
                || rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: mismatch exp st=%0d mac=%h rq=%b ip=%h rel=%b drop=%b last=%b",
                        $time, want.status, want.hw_addr_out, want.send_request,
                        want.request_ip, want.released_pending, want.dropped_pending,
                        want.last);
               $display("%0t:          got st=%0d mac=%h rq=%b ip=%h rel=%b drop=%b last=%b",
                        $time, rsp_data.status, rsp_data.hw_addr_out, rsp_data.send_request,
                        rsp_data.request_ip, rsp_data.released_pending,
                        rsp_data.dropped_pending, rsp_data.last);
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_reg(bit [1:0] idx, bit [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         anc_pkg::REG_REACH_TMO:  reach_tmo = val;
         anc_pkg::REG_INCOMP_TMO: incomp_tmo = val;
         anc_pkg::REG_RETRY_INT:  retry_int = val;
         default:                 retry_max = val[3:0];
      endcase
   endtask

   // one command transfer; expectations are formed at acceptance
   task automatic send_cmd(anc_pkg::req_type rq);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_cache(rq);
      items_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic anc_pkg::req_type make_cmd(logic [2:0] c, bit [31:0] ip, bit [47:0] mac,
                                                 bit [3:0] dev, bit all);
      anc_pkg::req_type r;
      r.command = c;
      r.ip_addr = ip;
      r.hw_addr = mac;
      r.dev_id = dev;
      r.flush_all = all;
      return r;
   endfunction

   // mostly well-formed neighbor traffic over a small address pool
   function automatic anc_pkg::req_type rand_cmd();
      anc_pkg::req_type r;
      int p;
      p = $urandom_range(99);
      r.ip_addr = ip_pool[$urandom_range(15)];
      if ($urandom_range(9) == 0) r.ip_addr = $urandom;
      r.hw_addr = ($urandom_range(5) == 0) ? 48'd0 : 48'({$urandom, $urandom});
      r.dev_id = 4'($urandom_range(15));
      r.flush_all = 1'($urandom_range(1));
      if (p < 20) r.command = anc_pkg::CMD_LOOKUP;
      else if (p < 40) r.command = anc_pkg::CMD_RESOLVE;
      else if (p < 60) r.command = anc_pkg::CMD_LEARN;
      else if (p < 70) r.command = anc_pkg::CMD_DELETE;
      else if (p < 73) r.command = anc_pkg::CMD_FLUSH;
      else if (p < 97) r.command = anc_pkg::CMD_TICK;
      else r.command = 3'($urandom_range(7));
      return r;
   endfunction

   // directed rows: typed expectations where obvious, else predictor only
   typedef struct {
      anc_pkg::req_type rq;
      bit typed;
      anc_pkg::rsp_type want;
   } stim_row_type;

   function automatic anc_pkg::rsp_type mk_rsp(anc_pkg::status_type st, bit [47:0] mac,
                                               bit req, bit [31:0] ip);
      anc_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.hw_addr_out = mac;
      r.send_request = req;
      r.request_ip = ip;
      r.last = 1'b1;
      return r;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type sr;
      anc_pkg::req_type rq;
      int phase_no;

      for (int i = 0; i < NSLOT; i++) nbr[i].valid = 0;
      tick_count = 0;
      reach_tmo = 60;
      incomp_tmo = 3;
      retry_int = 1;
      retry_max = 3;
      for (int i = 0; i < 16; i++) ip_pool[i] = $urandom;
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      sr.typed = 1;
      sr.rq = make_cmd(anc_pkg::CMD_LOOKUP, 32'h7F00_0001, 0, 0, 0);
      sr.want = mk_rsp(anc_pkg::ST_HIT, anc_pkg::LOOPBACK_MAC, 0, 32'h7F00_0001);
      rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 0, 0, 0);
      sr.want = mk_rsp(anc_pkg::ST_HIT, anc_pkg::LOOPBACK_MAC, 0, 32'h7FFF_FFFF);
      rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
      sr.want = mk_rsp(anc_pkg::ST_MISS, 0, 0, 32'hFFFF_FFFF); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_DELETE, 32'h0, 0, 0, 0);
      sr.want = mk_rsp(anc_pkg::ST_NOT_FOUND, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_FLUSH, 0, 0, 4'hF, 1);
      sr.want = mk_rsp(anc_pkg::ST_NOT_FOUND, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_TICK, 0, 0, 0, 0);
      sr.want = mk_rsp(anc_pkg::ST_TICK_DONE, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_RESOLVE, 32'h0A00_0001, 0, 4'h3, 0);
      sr.want = mk_rsp(anc_pkg::ST_QUEUED, 0, 1, 32'h0A00_0001); rows.push_back(sr);
      sr.typed = 0;
      sr.rq = make_cmd(anc_pkg::CMD_RESOLVE, 32'h0A00_0001, 0, 4'h3, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LOOKUP, 32'h0A00_0001, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LEARN, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 0, 0);
      rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LOOKUP, 32'h0A00_0001, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_RESOLVE, 32'h0A00_0001, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LEARN, 32'h0A00_0002, 0, 4'hF, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LEARN, 32'h0A00_0002, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_LEARN, 32'hFFFF_FFFF, 48'h1, 4'h3, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_RESOLVE, 32'h0A00_0003, 0, 0, 0); rows.push_back(sr);
      for (int k = 0; k < 5; k++) begin
         sr.rq = make_cmd(anc_pkg::CMD_TICK, 0, 0, 0, 0); rows.push_back(sr);
      end
      sr.rq = make_cmd(anc_pkg::CMD_FLUSH, 0, 0, 4'h3, 0); rows.push_back(sr);
      sr.rq = make_cmd(anc_pkg::CMD_DELETE, 32'h0A00_0002, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(3'd6, 0, 0, 0, 0); rows.push_back(sr);
      sr.rq = make_cmd(3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF, 1); rows.push_back(sr);

      foreach (rows[k]) begin
         send_cmd(rows[k].rq);
         if (rows[k].typed) begin
            // the typed row replaces the predicted one so the table governs
            expected_rsp[expected_rsp.size() - 1] = rows[k].want;
         end
      end
      wait_idle();

      // random phases across register settings and idle patterns
      for (phase_no = 0; phase_no < 5; phase_no++) begin
         case (phase_no)
            0: begin
               write_reg(anc_pkg::REG_REACH_TMO, 16'd1);
               write_reg(anc_pkg::REG_INCOMP_TMO, 16'd0);
               write_reg(anc_pkg::REG_RETRY_INT, 16'd0);
               write_reg(anc_pkg::REG_MAX_RETRY, 16'd0);
               send_idle_pct = 0; recv_stall_pct = 0;
            end
            1: begin
               write_reg(anc_pkg::REG_REACH_TMO, 16'd4);
               write_reg(anc_pkg::REG_INCOMP_TMO, 16'd2);
               write_reg(anc_pkg::REG_RETRY_INT, 16'd2);
               write_reg(anc_pkg::REG_MAX_RETRY, 16'd15);
               send_idle_pct = 67; recv_stall_pct = 0;
            end
            2: begin
               write_reg(anc_pkg::REG_REACH_TMO, 16'hFFFF);
               write_reg(anc_pkg::REG_INCOMP_TMO, 16'hFFFF);
               write_reg(anc_pkg::REG_RETRY_INT, 16'hFFFF);
               write_reg(anc_pkg::REG_MAX_RETRY, 16'd2);
               send_idle_pct = 0; recv_stall_pct = 67;
            end
            3: begin
               write_reg(anc_pkg::REG_REACH_TMO, 16'd3);
               write_reg(anc_pkg::REG_INCOMP_TMO, 16'd1);
               write_reg(anc_pkg::REG_RETRY_INT, 16'd1);
               write_reg(anc_pkg::REG_MAX_RETRY, 16'd1);
               send_idle_pct = 17; recv_stall_pct = 17;
            end
            default: begin
               write_reg(anc_pkg::REG_REACH_TMO, 16'd0);
               write_reg(anc_pkg::REG_INCOMP_TMO, 16'd5);
               write_reg(anc_pkg::REG_RETRY_INT, 16'd3);
               write_reg(anc_pkg::REG_MAX_RETRY, 16'd4);
               send_idle_pct = 0; recv_stall_pct = 0;
            end
         endcase
         for (int k = 0; k < 24; k++) begin
            rq = rand_cmd();
            send_cmd(rq);
            // hold off once per phase until every result is back
            if (k == 20) while (expected_rsp.size() != 0) @(posedge clock);
         end
         wait_idle();
      end

      // fill the table past capacity to force eviction
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int k = 0; k < NSLOT + 4; k++) begin
         rq = make_cmd((k % 2) ? anc_pkg::CMD_LEARN : anc_pkg::CMD_RESOLVE,
                       32'hC0A8_0000 + 32'(k), 48'({$urandom, $urandom}), 4'(k), 0);
         send_cmd(rq);
      end
      for (int k = 0; k < 4; k++) begin
         rq = make_cmd(anc_pkg::CMD_LEARN, 32'hC0A9_0000 + 32'(k),
                       48'({$urandom, $urandom}), 0, 0);
         send_cmd(rq);
      end
      send_cmd(make_cmd(anc_pkg::CMD_FLUSH, 0, 0, 0, 1));
      wait_idle();

      $display("covered %0d commands and %0d results over 5 register settings and idle mixes",
               items_sent, rsp_seen);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
